// File: src/tcfpm_pkg.sv
package tcfpm_pkg;

	localparam int unsigned DEPTH_DEF    = 128;
	localparam int unsigned ID_WIDTH_DEF = 16;

	// Operation carried in the input tuser.
	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	// Kind of a result item.
	typedef enum logic [2:0] {
		KIND_PAIR      = 3'd0,
		KIND_WAIT0     = 3'd1,
		KIND_WAIT1     = 3'd2,
		KIND_NONE      = 3'd3,
		KIND_DROPPED   = 3'd4
	} kind_t;

	// Commands from the pairing control to the waiting ring.
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} ring_ctrl_t;

	// Status of the waiting ring as seen by the pairing control.
	typedef struct packed {
		logic empty;
		logic full;
	} ring_stat_t;

endpackage

// File: src/tcfpm_ring.sv
module tcfpm_ring import tcfpm_pkg::*; #(
	parameter int unsigned DEPTH    = DEPTH_DEF,
	parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ring_ctrl_t          ctrl,
	input  logic [ID_WIDTH-1:0] wdata,
	output ring_stat_t          stat,
	output logic [ID_WIDTH-1:0] head_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [ID_WIDTH-1:0] mem [DEPTH];

	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [AW-1:0]       cnt_q;
	logic [AW-1:0]       head_next;
	logic [AW-1:0]       tail_next;
	logic [ID_WIDTH-1:0] rdata_q;
	logic [ID_WIDTH-1:0] byp_data_q;
	logic                byp_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == LAST) ? '0 : p + AW'(1);
	endfunction

	always_comb begin
		head_next = head_q;
		tail_next = tail_q;
		if (ctrl.clear) begin
			head_next = '0;
			tail_next = '0;
		end else begin
			if (ctrl.pop) begin
				head_next = ptr_inc(head_q);
			end
			if (ctrl.push) begin
				tail_next = ptr_inc(tail_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			byp_q  <= 1'b0;
		end else begin
			head_q <= head_next;
			tail_q <= tail_next;
			if (ctrl.clear) begin
				cnt_q <= '0;
			end else if (ctrl.push) begin
				cnt_q <= cnt_q + AW'(1);
			end else if (ctrl.pop) begin
				cnt_q <= cnt_q - AW'(1);
			end
			// A push into the entry that is read this cycle is seen through the bypass.
			byp_q <= ctrl.push && !ctrl.clear && (tail_q == head_next);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && !ctrl.clear) begin
			mem[tail_q] <= wdata;
		end
		rdata_q    <= mem[head_next];
		byp_data_q <= wdata;
	end

	assign head_data  = byp_q ? byp_data_q : rdata_q;
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == LAST);

endmodule

// File: src/tcfpm_out_reg.sv
module tcfpm_out_reg import tcfpm_pkg::*; #(
	parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  kind_t               kind,
	input  logic [ID_WIDTH-1:0] first_id,
	input  logic [ID_WIDTH-1:0] second_id,
	input  logic                tready,
	output logic                can_load,
	output logic                tvalid,
	output kind_t               kind_q,
	output logic [ID_WIDTH-1:0] first_q,
	output logic [ID_WIDTH-1:0] second_q
);

	logic valid_q;

	assign can_load = !valid_q || tready;
	assign tvalid   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			kind_q   <= kind;
			first_q  <= first_id;
			second_q <= second_id;
		end
	end

endmodule

// File: src/two_class_fifo_pair_matcher.sv
// Pairs arriving members of two classes in first-come order.
// Input channel s_*: each transfer is either an arrival (operation 0) carrying
// a class bit and an id, or a finish (operation 1). An arrival whose opposite
// class has a member waiting is paired with the oldest one and a pair result
// goes out; otherwise the id waits in the ring, or is reported as dropped when
// DEPTH-1 members of its class already wait. A finish reports the oldest
// waiting member (or that none waits) and empties the ring.
// Output channel m_*: zero or one result per input transfer.
// A result is on m_tvalid in the cycle after its input transfer.
// Throughput: one input transfer per cycle while the output is not stalled.
// Only one class can wait at any time, so a single memory holds the waiting ids;
// each item does at most one push or one pop, and the head entry is prefetched
// from the memory, with a bypass when a push lands on the entry being read.
// When the receiver stalls, the output register holds its result and s_tready
// drops until the result is taken; items that make no result also wait.
// Reset clears the ring pointers and the output register; the memory itself
// is not cleared, as only entries written since the last finish are read.
module two_class_fifo_pair_matcher import tcfpm_pkg::*; #(
	parameter int unsigned DEPTH    = DEPTH_DEF,
	parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// member_id, zero-filled to whole bytes
	input  logic [((ID_WIDTH+7)/8)*8-1:0]     s_tdata,
	// bit 0: operation, bit 1: member_class
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// first_id in the low bits, then second_id, zero-filled to whole bytes
	output logic [((2*ID_WIDTH+7)/8)*8-1:0]   m_tdata,
	// result_kind
	output logic [2:0]                        m_tuser
);

	localparam int unsigned OD_W = ((2*ID_WIDTH+7)/8)*8;

	logic                accept;
	op_t                 operation;
	logic                member_class;
	logic [ID_WIDTH-1:0] member_id;

	ring_ctrl_t          ctrl;
	ring_stat_t          stat;
	logic [ID_WIDTH-1:0] head_data;

	// Class of the members now waiting; meaningful only when the ring is not empty.
	logic                wait_cls_q;

	logic                res_load;
	kind_t               res_kind;
	logic [ID_WIDTH-1:0] res_first;
	logic [ID_WIDTH-1:0] res_second;
	logic                can_load;
	kind_t               out_kind;
	logic [ID_WIDTH-1:0] out_first;
	logic [ID_WIDTH-1:0] out_second;

	assign operation    = op_t'(s_tuser[0]);
	assign member_class = s_tuser[1];
	assign member_id    = s_tdata[ID_WIDTH-1:0];

	assign s_tready = can_load;
	assign accept   = s_tvalid && can_load;

	// Decide what the accepted item does: pair, wait, drop, or finish.
	always_comb begin
		ctrl       = '0;
		res_load   = 1'b0;
		res_kind   = KIND_NONE;
		res_first  = '0;
		res_second = '0;
		if (accept) begin
			unique case (operation)
				OP_FINISH: begin
					res_load   = 1'b1;
					ctrl.clear = 1'b1;
					if (stat.empty) begin
						res_kind = KIND_NONE;
					end else begin
						res_kind  = wait_cls_q ? KIND_WAIT1 : KIND_WAIT0;
						res_first = head_data;
					end
				end
				OP_ARRIVE: begin
					if (!stat.empty && (wait_cls_q != member_class)) begin
						// The oldest member of the other class is the partner.
						res_load   = 1'b1;
						ctrl.pop   = 1'b1;
						res_kind   = KIND_PAIR;
						res_first  = member_class ? head_data : member_id;
						res_second = member_class ? member_id : head_data;
					end else if (stat.full) begin
						res_load  = 1'b1;
						res_kind  = KIND_DROPPED;
						res_first = member_id;
					end else begin
						ctrl.push = 1'b1;
					end
				end
				default: begin
					ctrl = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_cls_q <= 1'b0;
		end else if (ctrl.push) begin
			wait_cls_q <= member_class;
		end
	end

	tcfpm_ring #(
		.DEPTH    (DEPTH),
		.ID_WIDTH (ID_WIDTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.wdata     (member_id),
		.stat      (stat),
		.head_data (head_data)
	);

	tcfpm_out_reg #(
		.ID_WIDTH (ID_WIDTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.kind      (res_kind),
		.first_id  (res_first),
		.second_id (res_second),
		.tready    (m_tready),
		.can_load  (can_load),
		.tvalid    (m_tvalid),
		.kind_q    (out_kind),
		.first_q   (out_first),
		.second_q  (out_second)
	);

	assign m_tdata = OD_W'({out_second, out_first});
	assign m_tuser = out_kind;

endmodule
